/* design/hrgb_pkg.sv */
`timescale 1ns / 1ps

package hrgb_pkg;

   // Fixed-point scale: 960 hue steps per sector, 255 stands for 1.0
   localparam logic [9:0]  HUE_PER_SECTOR = 10'd960;
   localparam logic [7:0]  UNIT_LEVEL     = 8'd255;
   localparam logic [17:0] FULL_SCALE     = 18'd244800;

   // x / 244800 == ((x >> 6) * RECIP) >> 32, exact for x below 2^26
   localparam int          SCALE_SHIFT = 6;
   localparam logic [20:0] RECIP       = 21'd1122868;
   localparam int          RECIP_SHIFT = 32;

   // Cycles from an accepted beat to its result strobe
   localparam int LATENCY = 6;

   typedef enum logic [3:0] {
      SECTOR_RED_YELLOW   = 4'd0,
      SECTOR_YELLOW_GREEN = 4'd1,
      SECTOR_GREEN_CYAN   = 4'd2,
      SECTOR_CYAN_BLUE    = 4'd3,
      SECTOR_BLUE_MAGENTA = 4'd4,
      SECTOR_MAGENTA_RED  = 4'd5,
      SECTOR_WRAP         = 4'd6,
      SECTOR_OVER_LOW     = 4'd7,
      SECTOR_OVER_HIGH    = 4'd8
   } hrgb_sector_type;

   typedef struct packed {
      logic [12:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
   } hrgb_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } hrgb_rsp_type;

   typedef struct packed {
      hrgb_sector_type sector;
      logic [9:0]      frac;
      logic [7:0]      sat;
      logic [7:0]      bright;
   } hrgb_part_type;

   typedef struct packed {
      hrgb_sector_type sector;
      logic [7:0]      bright;
      logic [7:0]      p;
      logic [7:0]      q;
      logic [7:0]      t;
   } hrgb_level_type;

endpackage

/* design/hrgb_split.sv */
`timescale 1ns / 1ps

module hrgb_split (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  hrgb_pkg::hrgb_req_type in_data,
   output logic                  part_valid,
   output hrgb_pkg::hrgb_part_type part
);

   localparam logic [12:0] STEP = 13'(hrgb_pkg::HUE_PER_SECTOR);

   logic                    valid_ff;
   hrgb_pkg::hrgb_part_type part_ff;
   hrgb_pkg::hrgb_part_type part_in;
   hrgb_pkg::hrgb_sector_type sector;
   logic [12:0]             base;
   logic [12:0]             frac_wide;

   // Find the sector by comparing against every boundary at once
   always_comb begin
      priority if (in_data.hue >= STEP * 13'd8) begin
         sector = hrgb_pkg::SECTOR_OVER_HIGH;
         base   = STEP * 13'd8;
      end else if (in_data.hue >= STEP * 13'd7) begin
         sector = hrgb_pkg::SECTOR_OVER_LOW;
         base   = STEP * 13'd7;
      end else if (in_data.hue >= STEP * 13'd6) begin
         sector = hrgb_pkg::SECTOR_WRAP;
         base   = STEP * 13'd6;
      end else if (in_data.hue >= STEP * 13'd5) begin
         sector = hrgb_pkg::SECTOR_MAGENTA_RED;
         base   = STEP * 13'd5;
      end else if (in_data.hue >= STEP * 13'd4) begin
         sector = hrgb_pkg::SECTOR_BLUE_MAGENTA;
         base   = STEP * 13'd4;
      end else if (in_data.hue >= STEP * 13'd3) begin
         sector = hrgb_pkg::SECTOR_CYAN_BLUE;
         base   = STEP * 13'd3;
      end else if (in_data.hue >= STEP * 13'd2) begin
         sector = hrgb_pkg::SECTOR_GREEN_CYAN;
         base   = STEP * 13'd2;
      end else if (in_data.hue >= STEP) begin
         sector = hrgb_pkg::SECTOR_YELLOW_GREEN;
         base   = STEP;
      end else begin
         sector = hrgb_pkg::SECTOR_RED_YELLOW;
         base   = 13'd0;
      end
   end

   assign frac_wide = in_data.hue - base;

   always_comb begin
      part_in.sector = sector;
      part_in.frac   = frac_wide[9:0];
      part_in.sat    = in_data.saturation;
      part_in.bright = in_data.brightness;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
   end

   assign part_valid = valid_ff;
   assign part       = part_ff;

endmodule

/* design/hrgb_levels.sv */
`timescale 1ns / 1ps

module hrgb_levels (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     part_valid,
   input  hrgb_pkg::hrgb_part_type  part,
   output logic                     level_valid,
   output hrgb_pkg::hrgb_level_type level
);

   localparam int QL = hrgb_pkg::RECIP_SHIFT;

   // Stage A: products of saturation
   logic                      a_valid_ff;
   hrgb_pkg::hrgb_sector_type a_sector_ff;
   logic [7:0]                a_bright_ff;
   logic [17:0]               a_sf_ff, a_sf_in;
   logic [17:0]               a_sg_ff, a_sg_in;
   logic [15:0]               a_vp_ff, a_vp_in;
   logic [9:0]                comp;

   // Stage B: complements and p
   logic                      b_valid_ff;
   hrgb_pkg::hrgb_sector_type b_sector_ff;
   logic [7:0]                b_bright_ff;
   logic [17:0]               b_qa_ff, b_qa_in;
   logic [17:0]               b_ta_ff, b_ta_in;
   logic [7:0]                b_p_ff, b_p_in;
   logic [16:0]               p_sum;

   // Stage C: scale by brightness
   logic                      c_valid_ff;
   hrgb_pkg::hrgb_sector_type c_sector_ff;
   logic [7:0]                c_bright_ff;
   logic [7:0]                c_p_ff;
   logic [25:0]               c_vq_ff, c_vq_in;
   logic [25:0]               c_vt_ff, c_vt_in;

   // Stage D: divide by full scale through the reciprocal
   logic                      d_valid_ff;
   hrgb_pkg::hrgb_level_type  d_level_ff, d_level_in;
   logic [40:0]               q_prod, t_prod;

   assign comp    = hrgb_pkg::HUE_PER_SECTOR - part.frac;
   assign a_sf_in = 18'(part.sat) * 18'(part.frac);
   assign a_sg_in = 18'(part.sat) * 18'(comp);
   assign a_vp_in = 16'(part.bright) * 16'(hrgb_pkg::UNIT_LEVEL - part.sat);

   // x / 255 for x below 2^16 as (x + (x >> 8) + 1) >> 8
   assign p_sum   = 17'(a_vp_ff) + 17'(a_vp_ff[15:8]) + 17'd1;
   assign b_p_in  = p_sum[15:8];
   assign b_qa_in = hrgb_pkg::FULL_SCALE - a_sf_ff;
   assign b_ta_in = hrgb_pkg::FULL_SCALE - a_sg_ff;

   assign c_vq_in = 26'(b_bright_ff) * 26'(b_qa_ff);
   assign c_vt_in = 26'(b_bright_ff) * 26'(b_ta_ff);

   assign q_prod = 41'(c_vq_ff[25:hrgb_pkg::SCALE_SHIFT]) * 41'(hrgb_pkg::RECIP);
   assign t_prod = 41'(c_vt_ff[25:hrgb_pkg::SCALE_SHIFT]) * 41'(hrgb_pkg::RECIP);

   always_comb begin
      d_level_in.sector = c_sector_ff;
      d_level_in.bright = c_bright_ff;
      d_level_in.p      = c_p_ff;
      d_level_in.q      = q_prod[QL+7:QL];
      d_level_in.t      = t_prod[QL+7:QL];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= part_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_sector_ff <= part.sector;
      a_bright_ff <= part.bright;
      a_sf_ff     <= a_sf_in;
      a_sg_ff     <= a_sg_in;
      a_vp_ff     <= a_vp_in;

      b_sector_ff <= a_sector_ff;
      b_bright_ff <= a_bright_ff;
      b_qa_ff     <= b_qa_in;
      b_ta_ff     <= b_ta_in;
      b_p_ff      <= b_p_in;

      c_sector_ff <= b_sector_ff;
      c_bright_ff <= b_bright_ff;
      c_p_ff      <= b_p_ff;
      c_vq_ff     <= c_vq_in;
      c_vt_ff     <= c_vt_in;

      d_level_ff  <= d_level_in;
   end

   assign level_valid = d_valid_ff;
   assign level       = d_level_ff;

`ifndef SYNTH
   // Every blended level is a fraction of brightness
   assert_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_valid |-> (level.p <= level.bright) && (level.q <= level.bright)
                      && (level.t <= level.bright))
      else $error("blended level exceeds brightness");
`endif

endmodule

/* design/hrgb_route.sv */
`timescale 1ns / 1ps

module hrgb_route (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     level_valid,
   input  hrgb_pkg::hrgb_level_type level,
   output logic                     rsp_valid,
   output hrgb_pkg::hrgb_rsp_type   rsp_data
);

   logic                   rsp_valid_ff;
   hrgb_pkg::hrgb_rsp_type rsp_ff, rsp_in;

   always_comb begin
      unique case (level.sector)
         hrgb_pkg::SECTOR_RED_YELLOW,
         hrgb_pkg::SECTOR_WRAP: begin
            rsp_in = {level.bright, level.t, level.p};
         end
         hrgb_pkg::SECTOR_YELLOW_GREEN: begin
            rsp_in = {level.q, level.bright, level.p};
         end
         hrgb_pkg::SECTOR_GREEN_CYAN: begin
            rsp_in = {level.p, level.bright, level.t};
         end
         hrgb_pkg::SECTOR_CYAN_BLUE: begin
            rsp_in = {level.p, level.q, level.bright};
         end
         hrgb_pkg::SECTOR_BLUE_MAGENTA: begin
            rsp_in = {level.t, level.p, level.bright};
         end
         hrgb_pkg::SECTOR_MAGENTA_RED: begin
            rsp_in = {level.bright, level.p, level.q};
         end
         default: begin
            // hue past the wrap sector: drop to black
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= level_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   assert_over_black: assert property (@(posedge clock) disable iff (reset)
      level_valid && (level.sector == hrgb_pkg::SECTOR_OVER_LOW
                      || level.sector == hrgb_pkg::SECTOR_OVER_HIGH)
      |=> rsp_valid && (rsp_data == '0))
      else $error("out-of-range hue did not give black");

   assert_bright_channel: assert property (@(posedge clock) disable iff (reset)
      level_valid && level.sector != hrgb_pkg::SECTOR_OVER_LOW
                  && level.sector != hrgb_pkg::SECTOR_OVER_HIGH
      |=> rsp_valid && (rsp_data.red == $past(level.bright)
                        || rsp_data.green == $past(level.bright)
                        || rsp_data.blue == $past(level.bright)))
      else $error("no channel carries brightness");
`endif

endmodule

/* design/hsv_to_rgb_pixel.sv */
`timescale 1ns / 1ps
// HSV to RGB pixel converter, six register stages.
// An accepted beat passes the split register, level stages A to D and the route register.
// Throughput: one beat per cycle; busy is low whenever reset is low.
// The receiver cannot stall, so the pipeline always advances.
// Synchronous active-high reset clears all valid bits; busy is high during reset.

module hsv_to_rgb_pixel (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  hrgb_pkg::hrgb_req_type req_data,
   output logic                   rsp_valid,
   output hrgb_pkg::hrgb_rsp_type rsp_data
);

   logic                     accept;
   logic                     part_valid;
   hrgb_pkg::hrgb_part_type  part;
   logic                     level_valid;
   hrgb_pkg::hrgb_level_type level;

   assign busy   = reset;
   assign accept = start & ~busy;

   hrgb_split u_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_data    (req_data),
      .part_valid (part_valid),
      .part       (part)
   );

   hrgb_levels u_levels (
      .clock       (clock),
      .reset       (reset),
      .part_valid  (part_valid),
      .part        (part),
      .level_valid (level_valid),
      .level       (level)
   );

   hrgb_route u_route (
      .clock       (clock),
      .reset       (reset),
      .level_valid (level_valid),
      .level       (level),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTH
   assert_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, hrgb_pkg::LATENCY))
      else $error("result strobe without an accepted beat");
`endif

endmodule

/* verif/hsv_to_rgb_pixel_tb.sv */
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_tb;

   localparam int CYCLE_LIMIT  = 60000;
   localparam int RANDOM_BEATS = 1700;

   typedef struct {
      hrgb_pkg::hrgb_req_type px;
      bit                     drain_first;
   } pending_pixel_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   hrgb_pkg::hrgb_req_type req_data;
   logic                   rsp_valid;
   hrgb_pkg::hrgb_rsp_type rsp_data;

   pending_pixel_type      pixels_to_send[$];
   hrgb_pkg::hrgb_rsp_type rgb_due[$];
   int                     n_accepted;
   int                     n_checked;
   int                     errors;
   int                     cycle_count;

   hsv_to_rgb_pixel DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // v * (1 - s * frac / (255 * 960)), truncated
   function automatic logic [7:0] blend_level(int unsigned v, int unsigned s,
                                              int unsigned frac);
      int unsigned full;
      full = int'(hrgb_pkg::UNIT_LEVEL) * int'(hrgb_pkg::HUE_PER_SECTOR);
      return 8'((v * (full - s * frac)) / full);
   endfunction

   function automatic hrgb_pkg::hrgb_rsp_type convert_hsv(hrgb_pkg::hrgb_req_type px);
      hrgb_pkg::hrgb_sector_type sector;
      int unsigned               frac;
      int unsigned               v;
      int unsigned               s;
      logic [7:0]                p;
      logic [7:0]                q;
      logic [7:0]                t;
      logic [7:0]                b;
      hrgb_pkg::hrgb_rsp_type    rgb;
      v      = px.brightness;
      s      = px.saturation;
      sector = hrgb_pkg::hrgb_sector_type'(4'(px.hue / hrgb_pkg::HUE_PER_SECTOR));
      frac   = px.hue % hrgb_pkg::HUE_PER_SECTOR;
      b      = px.brightness;
      p      = 8'((v * (int'(hrgb_pkg::UNIT_LEVEL) - s)) / int'(hrgb_pkg::UNIT_LEVEL));
      q      = blend_level(v, s, frac);
      t      = blend_level(v, s, int'(hrgb_pkg::HUE_PER_SECTOR) - frac);
      case (sector)
         hrgb_pkg::SECTOR_RED_YELLOW,
         hrgb_pkg::SECTOR_WRAP:         rgb = '{b, t, p};
         hrgb_pkg::SECTOR_YELLOW_GREEN: rgb = '{q, b, p};
         hrgb_pkg::SECTOR_GREEN_CYAN:   rgb = '{p, b, t};
         hrgb_pkg::SECTOR_CYAN_BLUE:    rgb = '{p, q, b};
         hrgb_pkg::SECTOR_BLUE_MAGENTA: rgb = '{t, p, b};
         hrgb_pkg::SECTOR_MAGENTA_RED:  rgb = '{b, p, q};
         default:                       rgb = '0;
      endcase
      return rgb;
   endfunction

   function automatic logic [7:0] pick_level();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 8'd0;
      if (roll < 20) return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_pixel(int unsigned hue, int unsigned sat, int unsigned bright,
                              bit drain_first);
      pending_pixel_type item;
      item.px.hue        = 13'(hue);
      item.px.saturation = 8'(sat);
      item.px.brightness = 8'(bright);
      item.drain_first   = drain_first;
      pixels_to_send.push_back(item);
   endtask

   // Driver: a beat moves on an edge with start high and busy low
   always @(posedge clock) begin
      pending_pixel_type nxt;
      bit                took;
      bit                hold_off;
      bit                quiet;
      took  = start && !busy;
      quiet = (n_accepted >= 700) && (n_accepted < 1100);
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (took) begin
            rgb_due.push_back(convert_hsv(req_data));
            n_accepted <= n_accepted + 1;
         end
         // hold a refused beat on the bus unchanged
         if (!start || took) begin
            hold_off = (pixels_to_send.size() == 0);
            if (!hold_off && pixels_to_send[0].drain_first &&
                n_checked != n_accepted + int'(took))
               hold_off = 1'b1;
            if (!hold_off && !quiet && $urandom_range(0, 99) < 20)
               hold_off = 1'b1;
            if (hold_off) begin
               start <= 1'b0;
            end else begin
               nxt = pixels_to_send.pop_front();
               start    <= 1'b1;
               req_data <= nxt.px;
            end
         end
      end
   end

   // Monitor: every strobe is one result beat
   always @(posedge clock) begin
      hrgb_pkg::hrgb_rsp_type want;
      if (!reset && rsp_valid) begin
         n_checked <= n_checked + 1;
         if (rgb_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual r=%0d g=%0d b=%0d",
                     $time, rsp_data.red, rsp_data.green, rsp_data.blue);
         end else begin
            want = rgb_due.pop_front();
            if (rsp_data.red !== want.red || rsp_data.green !== want.green ||
                rsp_data.blue !== want.blue) begin
               errors++;
               $display("%0t: mismatch, expected r=%0d g=%0d b=%0d, actual r=%0d g=%0d b=%0d",
                        $time, want.red, want.green, want.blue,
                        rsp_data.red, rsp_data.green, rsp_data.blue);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("hsv_to_rgb_pixel_tb: done, errors");
      $finish;
   end

   initial begin
      int unsigned roll;
      int unsigned hue;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      n_accepted = 0;
      n_checked  = 0;
      errors     = 0;

      // sector edges, wrap past 360 degrees, out-of-range hue, level extremes
      queue_pixel(0,    255, 255, 0);
      queue_pixel(959,  255, 255, 0);
      queue_pixel(960,  255, 255, 0);
      queue_pixel(1919, 255, 200, 0);
      queue_pixel(1920, 255, 255, 0);
      queue_pixel(2880, 255, 255, 0);
      queue_pixel(3840, 200, 255, 0);
      queue_pixel(4800, 255, 255, 0);
      queue_pixel(5759, 255, 255, 0);
      queue_pixel(5760, 255, 255, 0);
      queue_pixel(6000, 128, 200, 0);
      queue_pixel(6719, 255, 255, 0);
      queue_pixel(6720, 255, 255, 0);
      queue_pixel(7000, 0,   0,   0);
      queue_pixel(8191, 255, 255, 0);
      queue_pixel(480,  0,   255, 0);
      queue_pixel(2400, 0,   128, 0);
      queue_pixel(3000, 255, 0,   0);
      queue_pixel(1000, 128, 77,  0);
      queue_pixel(4000, 77,  128, 0);
      queue_pixel(5000, 1,   254, 0);
      queue_pixel(480,  255, 255, 1);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 75)
            hue = $urandom_range(0, 5760);
         else if (roll < 85)
            hue = $urandom_range(5761, 6719);
         else
            hue = $urandom_range(0, 8191);
         queue_pixel(hue, pick_level(), pick_level(), i == 400 || i == 1300);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pixels_to_send.size() != 0 || start)
         @(posedge clock);
      while (n_checked != n_accepted)
         @(posedge clock);
      repeat (hrgb_pkg::LATENCY + 4) @(posedge clock);

      if (errors == 0 && rgb_due.size() == 0) begin
         $display("hsv_to_rgb_pixel_tb: done, clean");
      end else begin
         $display("hsv_to_rgb_pixel_tb: done, errors");
      end
      $finish;
   end

endmodule

/* hsv_to_rgb_pixel.f */
design/hrgb_pkg.sv
design/hrgb_split.sv
design/hrgb_levels.sv
design/hrgb_route.sv
design/hsv_to_rgb_pixel.sv
verif/hsv_to_rgb_pixel_tb.sv
